FILE: src/spc_pkg.sv
`timescale 1ns / 1ps
package spc_pkg;
  localparam int CW    = 20;            // coordinate / velocity width
  localparam int FB    = 12;            // fraction bits
  localparam int RADW  = FB + 1;        // radius width
  localparam int RSW   = RADW + 1;      // radius sum width
  localparam int RSQW  = 2 * RSW;       // squared radius sum width
  localparam int DSW   = RSW + 1;       // short displacement, exact whenever a hit is possible
  localparam int DSQW  = 2 * CW - 1;    // |d_i|^2 width
  localparam int D2W   = DSQW + 2;      // |d|^2 width
  localparam int RELW  = CW + 1;        // relative velocity width
  localparam int RPW   = RELW + CW;     // rel_i * d_i width
  localparam int RDW   = RPW + 2;       // rel . d width
  localparam int SPW   = CW + DSW;      // v_i * d_i width
  localparam int SW    = SPW + 2;       // v . d width
  localparam int NUMW  = SW + DSW + 1;  // 2 * |v.d| * |d_i|
  localparam int QW    = CW + 3;        // quotient bits, |q| <= 2 |v|
  localparam int DIVW  = RSQW;          // divisor width, |d|^2 < (ra+rb)^2 on a hit
  localparam int OSW   = QW + 2;        // sum width before saturation
  localparam int PIPE  = 3 + QW;        // front stages plus divider stages

  typedef struct packed {
    logic [2:0][CW-1:0] d;
    logic [2:0][CW-1:0] va;
    logic [2:0][CW-1:0] vb;
    logic [RADW-1:0]    ra;
    logic [RADW-1:0]    rb;
  } pair_t;

  typedef struct packed {
    logic               hit;
    logic [2:0][CW-1:0] va;
    logic [2:0][CW-1:0] vb;
    logic [5:0]         neg;
    logic [5:0][NUMW-1:0] num;
    logic [DIVW-1:0]    d2;
  } front_t;

  typedef struct packed {
    logic               hit;
    logic [5:0][CW-1:0] v;
    logic [5:0]         neg;
  } carry_t;
endpackage

FILE: src/spc_front.sv
`timescale 1ns / 1ps
module spc_front (
  input  logic           clk,
  input  logic           en,
  input  spc_pkg::pair_t pair,
  output spc_pkg::front_t fr
);
  import spc_pkg::*;

  // stage A: products
  logic        [DSQW-1:0]   a_dsq_r [3];
  logic signed [RPW-1:0]    a_rp_r  [3];
  logic signed [SPW-1:0]    a_pa_r  [3];
  logic signed [SPW-1:0]    a_pb_r  [3];
  logic        [RSQW-1:0]   a_rsq_r;
  logic        [2:0][CW-1:0] a_va_r, a_vb_r;
  logic signed [DSW-1:0]    a_ds_r  [3];

  // stage B: sums
  logic                     b_hit_r;
  logic signed [SW-1:0]     b_sa_r, b_sb_r;
  logic        [DIVW-1:0]   b_d2_r;
  logic        [2:0][CW-1:0] b_va_r, b_vb_r;
  logic signed [DSW-1:0]    b_ds_r  [3];

  // stage C: numerators
  front_t c_r;

  logic [RSW-1:0] rsum;
  assign rsum = {1'b0, pair.ra} + {1'b0, pair.rb};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [CW-1:0]   di, vai, vbi;
        logic signed [2*CW-1:0] sq;
        logic signed [RELW-1:0] rel;
        logic signed [DSW-1:0]  ds;
        di  = $signed(pair.d[i]);
        vai = $signed(pair.va[i]);
        vbi = $signed(pair.vb[i]);
        sq  = di * di;
        rel = RELW'(vai) - RELW'(vbi);
        ds  = di[DSW-1:0];
        a_dsq_r[i] <= sq[DSQW-1:0];
        a_rp_r[i]  <= RPW'(rel) * RPW'(di);
        a_pa_r[i]  <= SPW'(vai) * SPW'(ds);
        a_pb_r[i]  <= SPW'(vbi) * SPW'(ds);
        a_ds_r[i]  <= ds;
      end
      a_rsq_r <= rsum * rsum;
      a_va_r  <= pair.va;
      a_vb_r  <= pair.vb;
    end
  end

  logic [D2W-1:0]        d2_sum;
  logic signed [RDW-1:0] rd_sum;
  assign d2_sum = D2W'(a_dsq_r[0]) + D2W'(a_dsq_r[1]) + D2W'(a_dsq_r[2]);
  assign rd_sum = RDW'(a_rp_r[0]) + RDW'(a_rp_r[1]) + RDW'(a_rp_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      b_hit_r <= (d2_sum < D2W'(a_rsq_r)) && rd_sum[RDW-1];
      b_sa_r  <= SW'(a_pa_r[0]) + SW'(a_pa_r[1]) + SW'(a_pa_r[2]);
      b_sb_r  <= SW'(a_pb_r[0]) + SW'(a_pb_r[1]) + SW'(a_pb_r[2]);
      b_d2_r  <= d2_sum[DIVW-1:0];
      b_va_r  <= a_va_r;
      b_vb_r  <= a_vb_r;
      for (int i = 0; i < 3; i++) b_ds_r[i] <= a_ds_r[i];
    end
  end

  logic [SW-1:0] mag_a, mag_b;
  assign mag_a = b_sa_r[SW-1] ? SW'(-b_sa_r) : SW'(b_sa_r);
  assign mag_b = b_sb_r[SW-1] ? SW'(-b_sb_r) : SW'(b_sb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [DSW-1:0] ad;
        ad = b_ds_r[i][DSW-1] ? DSW'(-b_ds_r[i]) : DSW'(b_ds_r[i]);
        c_r.num[i]   <= {(NUMW-1)'(mag_a * ad), 1'b0};
        c_r.num[i+3] <= {(NUMW-1)'(mag_b * ad), 1'b0};
        c_r.neg[i]   <= b_sa_r[SW-1] ^ b_ds_r[i][DSW-1];
        c_r.neg[i+3] <= b_sb_r[SW-1] ^ b_ds_r[i][DSW-1];
      end
      c_r.hit <= b_hit_r;
      c_r.va  <= b_va_r;
      c_r.vb  <= b_vb_r;
      c_r.d2  <= b_d2_r;
    end
  end

  assign fr = c_r;
endmodule

FILE: src/spc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, rounded half away from zero.
module spc_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [spc_pkg::NUMW-1:0] num,
  input  logic [spc_pkg::DIVW-1:0] den,
  output logic [spc_pkg::QW-1:0]   q
);
  import spc_pkg::*;

  logic [DIVW-1:0] rem_r [QW];
  logic [QW-1:0]   low_r [QW];
  logic [QW-1:0]   q_r   [QW];
  logic [DIVW-1:0] den_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DIVW-1:0] rem_in, den_in;
    logic [QW-1:0]   low_in, q_in;
    logic [DIVW:0]   t, diff;
    logic            ge;
    if (k == 0) begin : g_first
      // quotient fits QW bits, so the high part is already below the divisor
      assign rem_in = num[QW+DIVW-1:QW];
      assign low_in = num[QW-1:0];
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
    end
    assign t    = {rem_in, low_in[QW-1]};
    assign ge   = t >= {1'b0, den_in};
    assign diff = t - {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DIVW-1:0] : t[DIVW-1:0];
        low_r[k] <= {low_in[QW-2:0], 1'b0};
        q_r[k]   <= {q_in[QW-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  logic rnd;
  assign rnd = {rem_r[QW-1], 1'b0} >= {1'b0, den_r[QW-1]};
  assign q   = q_r[QW-1] + QW'(rnd);
endmodule

FILE: src/sphere_pair_collision_response_top.sv
// Sphere pair collision response, one pair per cycle while the output is not stalled.
// Stages: 3 product/sum stages, 23 divider stages, 1 output stage.
// Throughput: one word per cycle unless the output stalls; the 23-stage restoring divider sets the depth.
// A stall on the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module sphere_pair_collision_response_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [spc_pkg::CW-1:0]   in_disp_x,
  input  logic signed [spc_pkg::CW-1:0]   in_disp_y,
  input  logic signed [spc_pkg::CW-1:0]   in_disp_z,
  input  logic signed [spc_pkg::CW-1:0]   in_vel_a_x,
  input  logic signed [spc_pkg::CW-1:0]   in_vel_a_y,
  input  logic signed [spc_pkg::CW-1:0]   in_vel_a_z,
  input  logic signed [spc_pkg::CW-1:0]   in_vel_b_x,
  input  logic signed [spc_pkg::CW-1:0]   in_vel_b_y,
  input  logic signed [spc_pkg::CW-1:0]   in_vel_b_z,
  input  logic        [spc_pkg::RADW-1:0] in_radius_a,
  input  logic        [spc_pkg::RADW-1:0] in_radius_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic signed [spc_pkg::CW-1:0]   out_new_a_x,
  output logic signed [spc_pkg::CW-1:0]   out_new_a_y,
  output logic signed [spc_pkg::CW-1:0]   out_new_a_z,
  output logic signed [spc_pkg::CW-1:0]   out_new_b_x,
  output logic signed [spc_pkg::CW-1:0]   out_new_b_y,
  output logic signed [spc_pkg::CW-1:0]   out_new_b_z
);
  import spc_pkg::*;

  logic            en;
  logic [PIPE-1:0] pv_r;
  logic            out_valid_r;
  pair_t           pair;
  front_t          fr;
  carry_t          cy_r [QW];
  logic [QW-1:0]   q [6];
  logic            hit_r;
  logic [5:0][CW-1:0] res_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign pair.d  = {in_disp_z, in_disp_y, in_disp_x};
  assign pair.va = {in_vel_a_z, in_vel_a_y, in_vel_a_x};
  assign pair.vb = {in_vel_b_z, in_vel_b_y, in_vel_b_x};
  assign pair.ra = in_radius_a;
  assign pair.rb = in_radius_b;

  spc_front u_front (.clk(clk), .en(en), .pair(pair), .fr(fr));

  for (genvar j = 0; j < 6; j++) begin : g_div
    spc_div u_div (.clk(clk), .en(en), .num(fr.num[j]), .den(fr.d2), .q(q[j]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cy_r[0].hit <= fr.hit;
      cy_r[0].v   <= {fr.vb, fr.va};
      cy_r[0].neg <= fr.neg;
      for (int k = 1; k < QW; k++) cy_r[k] <= cy_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r        <= {pv_r[PIPE-2:0], in_valid};
      out_valid_r <= pv_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= cy_r[QW-1].hit;
      for (int j = 0; j < 6; j++) begin
        logic signed [OSW-1:0] v, qs, s;
        v  = OSW'($signed(cy_r[QW-1].v[j]));
        qs = $signed({2'b00, q[j]});
        s  = cy_r[QW-1].neg[j] ? v + qs : v - qs;
        if (!cy_r[QW-1].hit)
          res_r[j] <= cy_r[QW-1].v[j];
        else if (s > OSW'(signed'({1'b0, {(CW-1){1'b1}}})))
          res_r[j] <= {1'b0, {(CW-1){1'b1}}};
        else if (s < OSW'(signed'({1'b1, {(CW-1){1'b0}}})))
          res_r[j] <= {1'b1, {(CW-1){1'b0}}};
        else
          res_r[j] <= s[CW-1:0];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_new_a_x = $signed(res_r[0]);
  assign out_new_a_y = $signed(res_r[1]);
  assign out_new_a_z = $signed(res_r[2]);
  assign out_new_b_x = $signed(res_r[3]);
  assign out_new_b_y = $signed(res_r[4]);
  assign out_new_b_z = $signed(res_r[5]);

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(pv_r) && out_valid_r)
    else $error("pipeline moved during a stall");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && pv_r[PIPE-1]) |=> out_valid_r)
    else $error("word lost at output stage");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> pv_r[0])
    else $error("accepted word not tracked");
endmodule
